// File: rtl/core/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, action codes,
// request/result structs and the per-cell control struct.
// Depends on nothing; every file of the block imports it.
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_LIMIT   = 65535;
  localparam int KEY_W       = 16;
  localparam int FIELD_CNT_W = 5;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request action codes
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DEPART = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] entry_key;
    logic             entry_kind;
    logic             entry_urgent;
  } in_t;

  typedef struct packed {
    logic                   ok;
    logic                   found;
    logic [KEY_W-1:0]       popped_key;
    logic                   popped_urgent;
    logic [FIELD_CNT_W-1:0] total_count;
    logic [FIELD_CNT_W-1:0] urgent_count;
  } out_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic             cmp;
    logic             del;
    logic             ins;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
    logic             urgent;
  } cell_ctrl_t;

endpackage

// File: rtl/core/tcpq_cell.sv
// One slot of the queue chain: holds a key and its urgent flag, compares
// against the request key and shifts left, right or loads the new entry.
// Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_cell import tcpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [SLOT_W-1:0] index,
  input  logic [KEY_W-1:0]  left_key,
  input  logic              left_urgent,
  input  logic [KEY_W-1:0]  right_key,
  input  logic              right_urgent,
  input  logic              pref_in,
  output logic              pref_out,
  output logic [KEY_W-1:0]  key,
  output logic              urgent,
  output logic              hit
);

  logic [CNT_W-1:0] idx;
  logic             held;

  assign idx      = CNT_W'(index);
  assign held     = idx < ctrl.count;
  // Pass the "delete point is at or left of here" flag down the chain
  assign pref_out = pref_in | hit;

  // Capture key match during the compare cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.cmp) begin
      hit <= held && (key == ctrl.key);
    end
  end

  // Shift left on delete, shift right or load on insert
  always_ff @(posedge clk) begin
    if (ctrl.del && pref_out) begin
      key    <= right_key;
      urgent <= right_urgent;
    end else if (ctrl.ins) begin
      if (idx > ctrl.pos) begin
        key    <= left_key;
        urgent <= left_urgent;
      end else if (idx == ctrl.pos) begin
        key    <= ctrl.key;
        urgent <= ctrl.urgent;
      end
    end
  end

endmodule

// File: rtl/core/two_class_priority_queue_top.sv
// Top level of the two-class priority queue: request handshake, control
// sequencer, counters and the chain of tcpq_cell slots.
// Depends on tcpq_pkg and tcpq_cell.
`timescale 1ns / 1ps

// Each request passes through a compare cycle, in which every slot checks
// its key against the request key, and an update cycle, in which the slot
// chain shifts by one place and the counts change. busy is high only during
// the compare cycle, so a new request can be started while the previous one
// updates. The result appears on result for exactly one cycle, marked by
// done, in the cycle after the update; it cannot be held off. There is no
// clearing pass after reset. The queue kind register may be written at any
// cycle the block is idle; cfg_ready is always high.
module two_class_priority_queue_top import tcpq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_t              request,
  output logic             done,
  output out_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t           state, state_next;
  in_t              req;
  logic             queue_kind;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ucount, ucount_next;
  cell_ctrl_t       ctrl;
  logic             accept;

  logic [KEY_W-1:0]     key_v  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] urg_v;
  logic [QUEUE_DEPTH-1:0] hit_v;
  logic [QUEUE_DEPTH:0]   pref_v;

  logic  found, hit_urgent, key_ok, add_ok, del_ok, apply;
  out_t  result_next;

  assign busy      = (state == S_CMP);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign apply     = (state == S_APPLY);

  // Hold the configured queue kind
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_kind <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      queue_kind <= cfg_data;
    end
  end

  // Latch request on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= request;
    end
  end

  // Sequence compare and update cycles
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: state_next = accept ? S_CMP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the request against the compare results
  assign found      = |hit_v;
  assign hit_urgent = |(hit_v & urg_v);
  assign key_ok     = (req.entry_key != '0) &&
                      ({1'b0, req.entry_key} < (KEY_W + 1)'(KEY_LIMIT));

  always_comb begin
    add_ok = 1'b0;
    del_ok = 1'b0;
    result_next = '0;
    count_next  = count;
    ucount_next = ucount;
    unique case (action_t'(req.action))
      ACT_ADD: begin
        add_ok = key_ok && (req.entry_kind == queue_kind) &&
                 (count < CNT_W'(QUEUE_DEPTH)) && !found;
        result_next.ok = add_ok;
        if (add_ok) begin
          count_next = count + 1'b1;
          if (req.entry_urgent) ucount_next = ucount + 1'b1;
        end
      end
      ACT_REMOVE: begin
        del_ok = found;
        result_next.ok = found;
        if (found) begin
          count_next = count - 1'b1;
          if (hit_urgent) ucount_next = ucount - 1'b1;
        end
      end
      ACT_DEPART: begin
        del_ok = (count != '0);
        result_next.ok = del_ok;
        if (del_ok) begin
          result_next.popped_key    = key_v[0];
          result_next.popped_urgent = urg_v[0];
          count_next = count - 1'b1;
          if (urg_v[0]) ucount_next = ucount - 1'b1;
        end
      end
      ACT_LOOKUP: begin
        result_next.ok    = 1'b1;
        result_next.found = found && key_ok;
      end
      default: result_next = '0;
    endcase
    result_next.total_count  = FIELD_CNT_W'(count_next);
    result_next.urgent_count = FIELD_CNT_W'(ucount_next);
  end

  // Advance counters and strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ucount <= '0;
      done   <= 1'b0;
    end else begin
      done <= apply;
      if (apply) begin
        count  <= count_next;
        ucount <= ucount_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      result <= result_next;
    end
  end

  // Broadcast control to the chain
  always_comb begin
    ctrl.cmp    = (state == S_CMP);
    ctrl.del    = apply && del_ok;
    ctrl.ins    = apply && add_ok;
    ctrl.pos    = req.entry_urgent ? ucount : count;
    ctrl.count  = count;
    ctrl.key    = req.entry_key;
    ctrl.urgent = req.entry_urgent;
  end

  // Depart deletes from the head; remove deletes at the matching slot
  assign pref_v[0] = (action_t'(req.action) == ACT_DEPART);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic             lu, ru;

    if (i == 0) begin : g_head
      assign lk = '0;
      assign lu = 1'b0;
    end else begin : g_mid
      assign lk = key_v[i-1];
      assign lu = urg_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rk = key_v[i];
      assign ru = urg_v[i];
    end else begin : g_body
      assign rk = key_v[i+1];
      assign ru = urg_v[i+1];
    end

    tcpq_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .index        (SLOT_W'(i)),
      .left_key     (lk),
      .left_urgent  (lu),
      .right_key    (rk),
      .right_urgent (ru),
      .pref_in      (pref_v[i]),
      .pref_out     (pref_v[i+1]),
      .key          (key_v[i]),
      .urgent       (urg_v[i]),
      .hit          (hit_v[i])
    );
  end

  // Checks on the sequencer, counters and chain
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("done without an update cycle");

  a_urgent_le_total: assert property (@(posedge clk) disable iff (rst)
    ucount <= count)
    else $error("urgent count exceeds total count");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    apply |-> $onehot0(hit_v))
    else $error("more than one slot matched the key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("count beyond queue depth");

endmodule
